@@ hw/rtl/encoder_knob_servo_positioner_assert.svh @@
// ----------------------------------------------------------------------------
// Encoder knob servo positioner - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ENCODER_KNOB_SERVO_POSITIONER_ASSERT_SVH
`define ENCODER_KNOB_SERVO_POSITIONER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define EKP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ekp assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define EKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ekp assertion failed");

`endif

@@ hw/rtl/ekp_pkg.sv @@
// ----------------------------------------------------------------------------
// ekp_pkg
// Types and constants shared by the encoder knob servo positioner.
// ----------------------------------------------------------------------------
package ekp_pkg;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MID        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_DB_WINDOW     = 16'd40;
    localparam logic [15:0] RST_HOLD_WINDOW   = 16'd800;
    localparam logic [15:0] RST_BEEP_MS       = 16'd80;
    localparam logic [7:0]  RST_COARSE_STEP   = 8'd5;
    localparam logic [7:0]  RST_MID_STEP      = 8'd2;
    localparam logic [7:0]  RST_FINE_STEP     = 8'd1;
    localparam logic [7:0]  RST_MAX_ANGLE     = 8'd180;
    localparam logic [7:0]  RST_CENTER_ANGLE  = 8'd90;

    // Extra window after the long-press time in which a release still counts
    localparam logic [16:0] GRACE_MS = 17'd50;

    // Step size modes
    localparam logic [1:0] MODE_COARSE = 2'd0;
    localparam logic [1:0] MODE_MID    = 2'd1;
    localparam logic [1:0] MODE_FINE   = 2'd2;

    typedef struct packed {
        logic [15:0] db_window;
        logic [15:0] hold_window;
        logic [15:0] beep_ms;
        logic [7:0]  coarse_step;
        logic [7:0]  mid_step;
        logic [7:0]  fine_step;
        logic [7:0]  max_angle;
        logic [7:0]  center_angle;
    } t_cfg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        button_level;
        logic        enc_data;
        logic        enc_clk;
    } t_item;

    typedef struct packed {
        logic       limit_hit;
        logic [1:0] step_mode;
        logic       beep_on;
        logic [7:0] angle;
    } t_res;

endpackage

@@ hw/rtl/ekp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ekp_cfg_regs
// Configuration register file: indexed writes, values held for the core.
// ----------------------------------------------------------------------------
module ekp_cfg_regs
    import ekp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, 8-bit registers take the low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.db_window     <= RST_DB_WINDOW;
            r_cfg.hold_window   <= RST_HOLD_WINDOW;
            r_cfg.beep_ms       <= RST_BEEP_MS;
            r_cfg.coarse_step   <= RST_COARSE_STEP;
            r_cfg.mid_step      <= RST_MID_STEP;
            r_cfg.fine_step     <= RST_FINE_STEP;
            r_cfg.max_angle     <= RST_MAX_ANGLE;
            r_cfg.center_angle  <= RST_CENTER_ANGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:   r_cfg.db_window     <= i_cfg_wdata;
                REG_LONG_PRESS: r_cfg.hold_window   <= i_cfg_wdata;
                REG_BEEP:       r_cfg.beep_ms       <= i_cfg_wdata;
                REG_COARSE:     r_cfg.coarse_step   <= i_cfg_wdata[7:0];
                REG_MID:        r_cfg.mid_step      <= i_cfg_wdata[7:0];
                REG_FINE:       r_cfg.fine_step     <= i_cfg_wdata[7:0];
                REG_MAX_ANGLE:  r_cfg.max_angle     <= i_cfg_wdata[7:0];
                REG_CENTER:     r_cfg.center_angle  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/ekp_core.sv @@
// ----------------------------------------------------------------------------
// ekp_core
// Knob state and per-sample logic: detent detection, button debounce,
// long/short press, limit beep and the clamped angle move.
// ----------------------------------------------------------------------------
module ekp_core
    import ekp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_adv,
    input  t_item i_item,
    output t_res  o_res
);

`include "encoder_knob_servo_positioner_assert.svh"

    // State
    logic        r_prev_clk,   n_prev_clk;
    logic        r_bstate,     n_bstate;
    logic [31:0] r_last,       n_last;
    logic [31:0] r_press,      n_press;
    logic        r_lf,         n_lf;
    logic        r_st,         n_st;
    logic        r_seen,       n_seen;
    logic [7:0]  r_angle,      n_angle;
    logic [1:0]  r_step_idx,   n_step_idx;
    logic        r_beep_act,   n_beep_act;
    logic [31:0] r_beep_until, n_beep_until;

    logic        det;
    logic        long_ev;
    logic        limit;
    logic [31:0] dt_chg;
    logic [31:0] dt_press;
    logic [31:0] dt_beep;
    logic [31:0] dt_short;
    logic [16:0] short_lim;
    logic [7:0]  step;
    logic [8:0]  up_sum;
    logic [7:0]  up_tgt;
    logic [7:0]  dn_raw;
    logic [7:0]  dn_tgt;
    logic [7:0]  tgt;

    // Next-state and result for the sample in the input register
    always_comb begin
        // detent on falling encoder clock
        det        = r_prev_clk & ~i_item.enc_clk;
        n_prev_clk = i_item.enc_clk;

        // button debounce
        n_bstate = r_bstate;
        n_last   = r_last;
        n_press  = r_press;
        n_lf     = r_lf;
        n_st     = r_st;
        n_seen   = r_seen;
        dt_chg   = i_item.time_ms - r_last;
        if ((i_item.button_level != r_bstate) && (dt_chg >= {16'd0, i_cfg.db_window})) begin
            n_bstate = i_item.button_level;
            n_last   = i_item.time_ms;
            n_seen   = 1'b1;
            if (!i_item.button_level) begin
                n_press = i_item.time_ms;
                n_lf    = 1'b0;
                n_st    = 1'b0;
            end
        end

        // long press
        dt_press = i_item.time_ms - n_press;
        long_ev  = ~n_bstate & ~n_lf & (dt_press >= {16'd0, i_cfg.hold_window});
        if (long_ev) begin
            n_lf = 1'b1;
        end

        // beep expiry, half-range wrap compare
        n_beep_act   = r_beep_act;
        n_beep_until = r_beep_until;
        dt_beep      = i_item.time_ms - r_beep_until;
        if (r_beep_act && !dt_beep[31]) begin
            n_beep_act = 1'b0;
        end

        // step size for the current mode
        case (r_step_idx)
            MODE_COARSE: step = i_cfg.coarse_step;
            MODE_MID:    step = i_cfg.mid_step;
            default:     step = i_cfg.fine_step;
        endcase

        // clamped targets for both directions
        up_sum = {1'b0, r_angle} + {1'b0, step};
        up_tgt = (up_sum > {1'b0, i_cfg.max_angle}) ? i_cfg.max_angle : up_sum[7:0];
        dn_raw = (step >= r_angle) ? 8'd0 : (r_angle - step);
        dn_tgt = (dn_raw > i_cfg.max_angle) ? i_cfg.max_angle : dn_raw;
        tgt    = i_item.enc_data ? up_tgt : dn_tgt;

        // detent move or blocked-at-limit beep
        n_angle = r_angle;
        limit   = 1'b0;
        if (det) begin
            if (tgt == r_angle) begin
                limit        = 1'b1;
                n_beep_act   = 1'b1;
                n_beep_until = i_item.time_ms + {16'd0, i_cfg.beep_ms};
            end else begin
                n_angle = tgt;
            end
        end

        // short press: once per release
        n_step_idx = r_step_idx;
        short_lim  = {1'b0, i_cfg.hold_window} + GRACE_MS;
        dt_short   = i_item.time_ms - n_last;
        if (n_bstate && n_seen && !n_lf && !n_st && (dt_short < {15'd0, short_lim})) begin
            n_st = 1'b1;
            case (r_step_idx)
                MODE_COARSE: n_step_idx = MODE_MID;
                MODE_MID:    n_step_idx = MODE_FINE;
                default:     n_step_idx = MODE_COARSE;
            endcase
        end

        // long press recenters after everything else
        if (long_ev) begin
            n_angle = i_cfg.center_angle;
        end

        o_res.angle     = n_angle;
        o_res.beep_on   = n_beep_act;
        o_res.step_mode = n_step_idx;
        o_res.limit_hit = limit;
    end

    // State update, one sample per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk   <= 1'b1;
            r_bstate     <= 1'b1;
            r_last       <= '0;
            r_press      <= '0;
            r_lf         <= 1'b0;
            r_st         <= 1'b0;
            r_seen       <= 1'b0;
            r_angle      <= RST_CENTER_ANGLE;
            r_step_idx   <= MODE_COARSE;
            r_beep_act   <= 1'b0;
            r_beep_until <= '0;
        end else if (i_adv) begin
            r_prev_clk   <= n_prev_clk;
            r_bstate     <= n_bstate;
            r_last       <= n_last;
            r_press      <= n_press;
            r_lf         <= n_lf;
            r_st         <= n_st;
            r_seen       <= n_seen;
            r_angle      <= n_angle;
            r_step_idx   <= n_step_idx;
            r_beep_act   <= n_beep_act;
            r_beep_until <= n_beep_until;
        end
    end

    // Checks
    `EKP_ASSERT_NEXT(a_step_hold, i_clk, i_rst_n, !i_adv, $stable(r_step_idx))
    `EKP_ASSERT_NEXT(a_angle_quiet, i_clk, i_rst_n, i_adv && !det && !long_ev,
        $stable(r_angle))
    `EKP_ASSERT_NEXT(a_long_center, i_clk, i_rst_n, i_adv && long_ev,
        r_angle == $past(i_cfg.center_angle))
    `EKP_ASSERT_NEXT(a_limit_beeps, i_clk, i_rst_n, i_adv && limit,
        r_beep_act && r_lf == $past(n_lf))

endmodule

@@ hw/rtl/encoder_knob_servo_positioner.sv @@
// ----------------------------------------------------------------------------
// encoder_knob_servo_positioner
// Rotary encoder knob with debounced button driving a servo angle command.
//
//   Channel   Dir  Signals                       Contents (lsb first)
//   s_axis    in   tvalid/tready/tdata[39:0]     enc_clk, enc_data,
//                                                button_level, time_ms
//   m_axis    out  tvalid/tready/tdata[15:0]     angle, beep_on, step_mode,
//                                                limit_hit
//   cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata register writes, no wait
//
// Result is registered: the input register feeds the state logic, which loads
// the result register once it is free. One sample per cycle is sustained
// while the output does not stall; the state update is a single pass.
// Reset is synchronous active low and restores registers and knob state.
// A stalled output holds its result; the input register keeps accepting
// as long as the result register is free or draining.
// ----------------------------------------------------------------------------
module encoder_knob_servo_positioner
    import ekp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // enc_clk, enc_data, button_level, time_ms[31:0]
    // stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // angle[7:0], beep_on, step_mode[1:0], limit_hit
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg  cfg;
    t_item r_in;
    logic  r_in_vld;
    t_res  r_out;
    logic  r_out_vld;
    t_res  res;
    logic  adv;

    // Sample moves into the result register when that register is free
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    ekp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ekp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[$bits(t_item)-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_res)){1'b0}}, r_out};

endmodule

@@ bench/tb_encoder_knob_servo_positioner.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_knob_servo_positioner
// Self-checking bench for the encoder knob servo positioner. Pin samples go
// in on the input stream. A behavioral model of the knob (detents, clamp,
// limit beep, button debounce, short and long press) predicts every servo
// command, and each output transfer is compared field by field. Directed
// cases come first, then register extremes, then randomized knob use
// under three idling mixes.
// ----------------------------------------------------------------------------
module tb_encoder_knob_servo_positioner;
    timeunit 1ns;
    timeprecision 1ps;
    import ekp_pkg::*;

    // DUT ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // enc_clk, enc_data, button_level, time_ms
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // angle, beep_on, step_mode, limit_hit
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // Knob model: register copy and state
    t_cfg        knob_cfg;
    logic        prev_clk_q, btn_state_q, long_fired_q, short_taken_q;
    logic        beep_active_q, change_seen_q;
    logic [31:0] last_change_q, press_start_q, beep_until_q;
    logic [7:0]  angle_q;
    logic [1:0]  step_mode_q;

    // Servo commands predicted but not yet seen on the output
    t_res servo_cmd_q[$];

    // Stimulus levels and clock of the sampled pins
    logic        enc_clk_lvl  = 1'b1;
    logic        enc_data_lvl = 1'b0;
    logic        btn_lvl      = 1'b1;
    logic [31:0] now_ms       = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count      = 0;
    int unsigned n_samples      = 0;
    int unsigned n_checked      = 0;
    int unsigned n_blocked      = 0;
    int unsigned n_step_changes = 0;
    int unsigned n_recenters    = 0;

    encoder_knob_servo_positioner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Model state after reset
    task automatic knob_reset_model();
        knob_cfg.db_window     = RST_DB_WINDOW;
        knob_cfg.hold_window   = RST_HOLD_WINDOW;
        knob_cfg.beep_ms       = RST_BEEP_MS;
        knob_cfg.coarse_step   = RST_COARSE_STEP;
        knob_cfg.mid_step      = RST_MID_STEP;
        knob_cfg.fine_step     = RST_FINE_STEP;
        knob_cfg.max_angle     = RST_MAX_ANGLE;
        knob_cfg.center_angle  = RST_CENTER_ANGLE;
        prev_clk_q    = 1'b1;
        btn_state_q   = 1'b1;
        last_change_q = '0;
        press_start_q = '0;
        long_fired_q  = 1'b0;
        short_taken_q = 1'b0;
        beep_active_q = 1'b0;
        change_seen_q = 1'b0;
        angle_q       = RST_CENTER_ANGLE;
        step_mode_q   = MODE_COARSE;
        beep_until_q  = '0;
    endtask

    // Advance the knob model by one pin sample, return the servo command
    function automatic t_res knob_advance(input t_item it);
        logic [31:0] now;
        logic [31:0] since_beep;
        logic [7:0]  step;
        logic [8:0]  target;
        logic        turned;
        logic        long_event;
        logic        blocked;
        t_res        r;
        now        = it.time_ms;
        long_event = 1'b0;
        blocked    = 1'b0;

        // detent on falling encoder clock
        turned     = (it.enc_clk != prev_clk_q) && !it.enc_clk;
        prev_clk_q = it.enc_clk;

        // debounce, then long-press detection
        if (it.button_level != btn_state_q &&
            (now - last_change_q) >= 32'(knob_cfg.db_window)) begin
            btn_state_q   = it.button_level;
            last_change_q = now;
            change_seen_q = 1'b1;
            if (!it.button_level) begin
                press_start_q = now;
                long_fired_q  = 1'b0;
                short_taken_q = 1'b0;
            end
        end
        if (!btn_state_q && !long_fired_q &&
            (now - press_start_q) >= 32'(knob_cfg.hold_window)) begin
            long_fired_q = 1'b1;
            long_event   = 1'b1;
        end

        // beep ends once time reaches its deadline (half-range compare)
        since_beep = now - beep_until_q;
        if (beep_active_q && !since_beep[31])
            beep_active_q = 1'b0;

        // move with clamp; no movement means blocked
        if (turned) begin
            case (step_mode_q)
                MODE_COARSE: step = knob_cfg.coarse_step;
                MODE_MID:    step = knob_cfg.mid_step;
                default:     step = knob_cfg.fine_step;
            endcase
            if (it.enc_data)
                target = {1'b0, angle_q} + {1'b0, step};
            else
                target = (step >= angle_q) ? 9'd0 : {1'b0, angle_q - step};
            if (target > {1'b0, knob_cfg.max_angle})
                target = {1'b0, knob_cfg.max_angle};
            if (target == {1'b0, angle_q}) begin
                blocked       = 1'b1;
                beep_active_q = 1'b1;
                beep_until_q  = now + 32'(knob_cfg.beep_ms);
                n_blocked++;
            end else begin
                angle_q = target[7:0];
            end
        end

        // short press, once per release
        if (btn_state_q && change_seen_q && !long_fired_q && !short_taken_q &&
            (now - last_change_q) < 32'(knob_cfg.hold_window) + 32'(GRACE_MS)) begin
            short_taken_q = 1'b1;
            n_step_changes++;
            case (step_mode_q)
                MODE_COARSE: step_mode_q = MODE_MID;
                MODE_MID:    step_mode_q = MODE_FINE;
                default:     step_mode_q = MODE_COARSE;
            endcase
        end

        if (long_event) begin
            angle_q = knob_cfg.center_angle;
            n_recenters++;
        end

        r.angle     = angle_q;
        r.beep_on   = beep_active_q;
        r.step_mode = step_mode_q;
        r.limit_hit = blocked;
        return r;
    endfunction

    // Send one pin sample, with random idle cycles ahead of it
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(it);
        do @(posedge i_clk); while (!s_axis_tready);
        servo_cmd_q.push_back(knob_advance(it));
        n_samples++;
    endtask

    // Sample the current pin levels dt ms after the previous sample
    task automatic knob_sample(input int unsigned dt);
        t_item it;
        now_ms          = now_ms + dt;
        it.time_ms      = now_ms;
        it.button_level = btn_lvl;
        it.enc_data     = enc_data_lvl;
        it.enc_clk      = enc_clk_lvl;
        send_item(it);
    endtask

    // Hold off the input until every predicted command has come out
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (servo_cmd_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE:   knob_cfg.db_window     = data;
            REG_LONG_PRESS: knob_cfg.hold_window   = data;
            REG_BEEP:       knob_cfg.beep_ms       = data;
            REG_COARSE:     knob_cfg.coarse_step   = data[7:0];
            REG_MID:        knob_cfg.mid_step      = data[7:0];
            REG_FINE:       knob_cfg.fine_step     = data[7:0];
            REG_MAX_ANGLE:  knob_cfg.max_angle     = data[7:0];
            default:        knob_cfg.center_angle  = data[7:0];
        endcase
    endtask

    // Write all registers once the block is idle; byte registers get junk
    // in the unused upper byte
    task automatic program_regs(input t_cfg c);
        wait_results_drained();
        repeat (3) @(posedge i_clk);
        write_reg(REG_DEBOUNCE,   c.db_window);
        write_reg(REG_LONG_PRESS, c.hold_window);
        write_reg(REG_BEEP,       c.beep_ms);
        write_reg(REG_COARSE,     {8'($urandom), c.coarse_step});
        write_reg(REG_MID,        {8'($urandom), c.mid_step});
        write_reg(REG_FINE,       {8'($urandom), c.fine_step});
        write_reg(REG_MAX_ANGLE,  {8'($urandom), c.max_angle});
        write_reg(REG_CENTER,     {8'($urandom), c.center_angle});
        i_cfg_we <= 1'b0;
    endtask

    // Random knob use: turns, button gestures, quiet time and pin noise
    task automatic run_gestures(input int unsigned n_items);
        int unsigned stop_at, pick, detents, holds, hold_ms, deb, lp;
        logic        up, bounce;
        stop_at = n_samples + n_items;
        while (n_samples < stop_at) begin
            pick = $urandom_range(99);
            deb  = 32'(knob_cfg.db_window);
            lp   = 32'(knob_cfg.hold_window);
            if (pick < 45) begin
                // a burst of detents, mostly one way
                up      = 1'($urandom_range(1));
                detents = $urandom_range(1, 8);
                repeat (detents) begin
                    enc_clk_lvl  = 1'b0;
                    enc_data_lvl = ($urandom_range(9) == 0) ? !up : up;
                    knob_sample($urandom_range(20));
                    enc_clk_lvl  = 1'b1;
                    enc_data_lvl = 1'($urandom_range(1));
                    knob_sample($urandom_range(20));
                end
            end else if (pick < 75) begin
                // press, optional bounce, hold, release
                bounce  = ($urandom_range(3) == 0);
                btn_lvl = 1'b0;
                knob_sample($urandom_range(deb + 30));
                if (bounce) begin
                    btn_lvl = 1'b1;
                    knob_sample($urandom_range(deb));
                    btn_lvl = 1'b0;
                    knob_sample($urandom_range(5));
                end
                case ($urandom_range(2))
                    0:       hold_ms = $urandom_range(lp);
                    1:       hold_ms = (lp > 50 ? lp - 50 : 0) + $urandom_range(100);
                    default: hold_ms = lp + $urandom_range(lp + 200);
                endcase
                holds = $urandom_range(1, 4);
                repeat (holds) begin
                    if ($urandom_range(3) == 0) begin
                        enc_clk_lvl  = !enc_clk_lvl;
                        enc_data_lvl = 1'($urandom_range(1));
                    end
                    knob_sample(hold_ms / holds);
                end
                btn_lvl = 1'b1;
                knob_sample($urandom_range(deb + 20));
                if (bounce) begin
                    btn_lvl = 1'b0;
                    knob_sample($urandom_range(deb));
                    btn_lvl = 1'b1;
                    knob_sample($urandom_range(deb + 20));
                end
                knob_sample($urandom_range(lp + 100));
            end else if (pick < 90) begin
                // quiet time, around the beep length or longer
                if ($urandom_range(1))
                    knob_sample($urandom_range(knob_cfg.beep_ms + 20));
                else
                    knob_sample($urandom_range(3000));
            end else begin
                // pin noise at an arbitrary time
                now_ms       = $urandom;
                enc_clk_lvl  = 1'($urandom_range(1));
                enc_data_lvl = 1'($urandom_range(1));
                btn_lvl      = 1'($urandom_range(1));
                knob_sample(0);
            end
        end
    endtask

    // Detents both ways, debounce, short presses through all modes, long press
    task automatic test_detents_and_buttons();
        enc_clk_lvl = 1'b1; enc_data_lvl = 1'b0; btn_lvl = 1'b1;
        knob_sample(0);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b1; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(5);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b0; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(5);
        // press, bounce rejected by debounce, release -> mid
        btn_lvl = 1'b0; knob_sample(100);
        btn_lvl = 1'b1; knob_sample(10);
        btn_lvl = 1'b1; knob_sample(100);
        // two more short presses: fine, then back to coarse
        repeat (2) begin
            btn_lvl = 1'b0; knob_sample(60);
            btn_lvl = 1'b1; knob_sample(60);
        end
        // long hold recenters; its release must not change the step
        btn_lvl = 1'b0; knob_sample(60);
        btn_lvl = 1'b0; knob_sample(900);
        btn_lvl = 1'b1; knob_sample(60);
    endtask

    // Clamp above max, blocked detents at both ends, beep timing and wrap,
    // zero step size
    task automatic test_limits_and_beep();
        t_cfg c;
        c             = knob_cfg;
        c.max_angle   = 8'd40;
        c.coarse_step = 8'd200;
        c.beep_ms     = 16'd30;
        program_regs(c);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b1; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(5);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b1; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(10);
        knob_sample(25);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b0; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(5);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b0; knob_sample(5);
        // beep deadline across the 32-bit time wrap
        enc_clk_lvl = 1'b1;
        now_ms      = 32'hFFFF_FFF0;
        knob_sample(0);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b0; knob_sample(0);
        enc_clk_lvl = 1'b1;                      knob_sample(20);
        knob_sample(20);
        c.coarse_step = 8'd0;
        program_regs(c);
        enc_clk_lvl = 1'b0; enc_data_lvl = 1'b1; knob_sample(5);
        enc_clk_lvl = 1'b1;                      knob_sample(5);
    endtask

    // All-zero, all-ones and center-above-max register settings
    task automatic test_register_extremes();
        t_cfg c;
        c = '0;
        program_regs(c);
        run_gestures(40);
        c = '1;
        program_regs(c);
        run_gestures(40);
        c.db_window     = 16'd20;
        c.hold_window   = 16'd300;
        c.beep_ms       = 16'd50;
        c.coarse_step   = 8'd7;
        c.mid_step      = 8'd3;
        c.fine_step     = 8'd1;
        c.max_angle     = 8'd50;
        c.center_angle  = 8'd200;
        program_regs(c);
        run_gestures(40);
    endtask

    // Randomized use under one idling mix, pausing now and then until the
    // output has caught up
    task automatic test_random_use(input int unsigned n_items,
                                   input int unsigned send_pct,
                                   input int unsigned recv_pct);
        t_cfg        c;
        int unsigned stop_at;
        int unsigned chunk;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        c.db_window     = 16'($urandom_range(80));
        c.hold_window   = 16'($urandom_range(100, 1500));
        c.beep_ms       = 16'($urandom_range(400));
        c.coarse_step   = 8'($urandom_range(180));
        c.mid_step      = 8'($urandom_range(20));
        c.fine_step     = 8'($urandom_range(5));
        c.max_angle     = 8'($urandom_range(255));
        c.center_angle  = 8'($urandom_range(255));
        program_regs(c);
        stop_at = n_samples + n_items;
        while (n_samples < stop_at) begin
            chunk = $urandom_range(60, 160);
            if (chunk > stop_at - n_samples)
                chunk = stop_at - n_samples;
            run_gestures(chunk);
            wait_results_drained();
        end
    endtask

    // Output side: random stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each output transfer with the oldest predicted command
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_res)-1:0];
            if (servo_cmd_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = servo_cmd_q.pop_front();
                n_checked++;
                if (got.angle !== want.angle) begin
                    $error("angle: expected %0d, got %0d", want.angle, got.angle);
                    err_count++;
                end
                if (got.beep_on !== want.beep_on) begin
                    $error("beep_on: expected %0d, got %0d", want.beep_on, got.beep_on);
                    err_count++;
                end
                if (got.step_mode !== want.step_mode) begin
                    $error("step_mode: expected %0d, got %0d",
                           want.step_mode, got.step_mode);
                    err_count++;
                end
                if (got.limit_hit !== want.limit_hit) begin
                    $error("limit_hit: expected %0d, got %0d",
                           want.limit_hit, got.limit_hit);
                    err_count++;
                end
            end
        end
    end

    // Test sequence
    initial begin
        knob_reset_model();
        send_idle_pct  = 16;
        recv_stall_pct = 60;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_detents_and_buttons();
        test_limits_and_beep();
        test_register_extremes();
        test_random_use(400, 16, 60);
        test_random_use(400, 60, 16);
        test_random_use(400, 0, 0);

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d pin samples, checked %0d servo commands", n_samples, n_checked);
        $display("Saw %0d blocked detents, %0d step changes, %0d recenters",
                 n_blocked, n_step_changes, n_recenters);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
